@@ rtl/yrs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yrs_pkg: shared types and constants of the YUV 4:2:0 to RGB converter
// Sizes, store geometry, opcodes, register indexes, the sequencer states and
// the structs that travel between the front end, coordinate unit and back end.
// ----------------------------------------------------------------------------
package yrs_pkg;

   // Frame limits and store geometry.
   localparam int MAX_WIDTH   = 256;
   localparam int MAX_HEIGHT  = 256;
   localparam int LUMA_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int CA_DEPTH    = LUMA_DEPTH / 2;
   localparam int CB_DEPTH    = LUMA_DEPTH / 4;
   localparam int LUMA_AW     = $clog2(LUMA_DEPTH);
   localparam int CA_AW       = $clog2(CA_DEPTH);
   localparam int CB_AW       = $clog2(CB_DEPTH);

   // Field widths.
   localparam int DIM_W       = 9;
   localparam int ORIENT_W    = 3;
   localparam int OP_W        = 2;
   localparam int ADDR_W      = 16;
   localparam int BYTE_W      = 8;
   localparam int PIX_W       = 8;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 9;
   localparam int COORD_W     = $clog2((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT);

   // Divider: numerator is an output coordinate times a natural size.
   localparam int NUM_W       = PIX_W + DIM_W;
   localparam int DIV_CNT_W   = $clog2(NUM_W + 1);

   // Front queue.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // BT.601 integer conversion.
   localparam int CONV_W = 20;
   localparam int FRAC_W = 8;
   localparam logic signed [CONV_W-1:0] C_Y     = 298;
   localparam logic signed [CONV_W-1:0] C_RV    = 409;
   localparam logic signed [CONV_W-1:0] C_GU    = 100;
   localparam logic signed [CONV_W-1:0] C_GV    = 208;
   localparam logic signed [CONV_W-1:0] C_BU    = 516;
   localparam logic signed [CONV_W-1:0] C_ROUND = 128;

   typedef enum logic [OP_W-1:0] {
      OP_WR_LUMA = 2'd0,
      OP_WR_CA   = 2'd1,
      OP_WR_CB   = 2'd2,
      OP_READ    = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SRC_WIDTH     = 3'd0,
      CSR_SRC_HEIGHT    = 3'd1,
      CSR_OUT_WIDTH     = 3'd2,
      CSR_OUT_HEIGHT    = 3'd3,
      CSR_ORIENTATION   = 3'd4,
      CSR_CHROMA_FORMAT = 3'd5,
      CSR_LUMA_STRIDE   = 3'd6,
      CSR_CHROMA_STRIDE = 3'd7
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'd0,
      ST_MAP  = 3'd1,
      ST_ADDR = 3'd2,
      ST_RD0  = 3'd3,
      ST_RD1  = 3'd4,
      ST_RD2  = 3'd5,
      ST_MUL  = 3'd6,
      ST_OUT  = 3'd7
   } state_type;

   typedef struct packed {
      logic [DIM_W-1:0]    src_width;
      logic [DIM_W-1:0]    src_height;
      logic [DIM_W-1:0]    out_width;
      logic [DIM_W-1:0]    out_height;
      logic [ORIENT_W-1:0] orientation;
      logic                chroma_format;
      logic [DIM_W-1:0]    luma_stride;
      logic [DIM_W-1:0]    chroma_stride;
   } cfg_type;

   typedef struct packed {
      op_type              op;
      logic [ADDR_W-1:0]   address;
      logic [BYTE_W-1:0]   value;
      logic [PIX_W-1:0]    out_x;
      logic [PIX_W-1:0]    out_y;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_type;

   typedef struct packed {
      logic             start;
      logic [PIX_W-1:0] out_x;
      logic [PIX_W-1:0] out_y;
   } coord_req_type;

   typedef struct packed {
      logic               done;
      logic [COORD_W-1:0] sx;
      logic [COORD_W-1:0] sy;
   } coord_rsp_type;

endpackage
`default_nettype wire

@@ rtl/yrs_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yrs_if: channel interfaces of the converter
// Request, response and register write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface yrs_req_if import yrs_pkg::*; ();
   logic             valid;
   logic             ready;
   op_type           op;
   logic [ADDR_W-1:0] address;
   logic [BYTE_W-1:0] value;
   logic [PIX_W-1:0] out_x;
   logic [PIX_W-1:0] out_y;

   modport source(output valid, op, address, value, out_x, out_y, input ready);
   modport sink(input valid, op, address, value, out_x, out_y, output ready);
endinterface

interface yrs_rsp_if import yrs_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] red;
   logic [PIX_W-1:0] green;
   logic [PIX_W-1:0] blue;

   modport source(output valid, red, green, blue, input ready);
   modport sink(input valid, red, green, blue, output ready);
endinterface

interface yrs_csr_if import yrs_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/yrs_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yrs_ram: generic single-port RAM
// One write or one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module yrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Storage array and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

@@ rtl/yrs_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yrs_front: request front end
// Accepts request words and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module yrs_front import yrs_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   yrs_req_if.sink   req,
   output queue_type q,
   input  logic      pop
);

   item_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              accept;
   logic              take;
   item_type          item_in;

   // Space check and request capture.
   assign req.ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign accept    = req.valid && req.ready;
   assign take      = pop && (count_ff != '0);

   always_comb begin
      item_in.op      = req.op;
      item_in.address = req.address;
      item_in.value   = req.value;
      item_in.out_x   = req.out_x;
      item_in.out_y   = req.out_y;
   end

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = accept ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = take ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (accept && !take) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (take && !accept) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         slot_ff[wr_ptr_ff] <= item_in;
      end
   end

   // Head of the queue.
   assign q.valid = (count_ff != '0);
   assign q.item  = slot_ff[rd_ptr_ff];

endmodule
`default_nettype wire

@@ rtl/yrs_coord.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yrs_coord: output-to-source coordinate mapper
// Nearest-neighbour scaling by a bit-serial divider, then mirror and rotation.
// ----------------------------------------------------------------------------
module yrs_coord import yrs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  coord_req_type creq,
   output coord_rsp_type crsp
);

   logic [DIM_W-1:0]     w_ff, w_in, h_ff, h_in;
   logic [DIM_W-1:0]     nw_ff, nw_in, nh_ff, nh_in;
   logic [DIM_W-1:0]     ow_ff, ow_in, oh_ff, oh_in;
   logic [ORIENT_W-1:0]  orient_ff, orient_in;
   logic [NUM_W-1:0]     numx_ff, numx_in, numy_ff, numy_in;
   logic [DIM_W-1:0]     remx_ff, remx_in, remy_ff, remy_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [COORD_W-1:0]   sx_ff, sx_in, sy_ff, sy_in;

   logic [DIM_W-1:0]     w_c, h_c, nw_c, nh_c, ow_c, oh_c;
   logic [DIM_W:0]       shx, shy;
   logic                 gex, gey;
   logic                 iterate, finish;
   logic [DIM_W-1:0]     lastx, lasty, lastw, lasth, nx, ny, mx;
   logic [DIM_W-1:0]     sx_w, sy_w;

   function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v, input int hi);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (int'(v) > hi) begin
         r = DIM_W'(hi);
      end
      return r;
   endfunction

   // Frame geometry taken at start.
   always_comb begin
      w_c  = sat_dim(cfg.src_width, MAX_WIDTH);
      h_c  = sat_dim(cfg.src_height, MAX_HEIGHT);
      nw_c = cfg.orientation[0] ? h_c : w_c;
      nh_c = cfg.orientation[0] ? w_c : h_c;
      ow_c = nw_c;
      oh_c = nh_c;
      if (!cfg.chroma_format) begin
         if (cfg.out_width != '0) begin
            ow_c = sat_dim(cfg.out_width, MAX_WIDTH);
         end
         if (cfg.out_height != '0) begin
            oh_c = sat_dim(cfg.out_height, MAX_HEIGHT);
         end
      end
   end

   // One restoring division step per cycle for each axis.
   always_comb begin
      shx = {remx_ff, numx_ff[NUM_W-1]};
      shy = {remy_ff, numy_ff[NUM_W-1]};
      gex = (shx >= {1'b0, ow_ff});
      gey = (shy >= {1'b0, oh_ff});
   end

   assign iterate = busy_ff && (cnt_ff != DIV_CNT_W'(NUM_W));
   assign finish  = busy_ff && (cnt_ff == DIV_CNT_W'(NUM_W));

   // Clamp to the last natural column or row, then mirror and rotate.
   always_comb begin
      lastx = nw_ff - DIM_W'(1);
      lasty = nh_ff - DIM_W'(1);
      lastw = w_ff - DIM_W'(1);
      lasth = h_ff - DIM_W'(1);
      nx    = (numx_ff > NUM_W'(lastx)) ? lastx : DIM_W'(numx_ff);
      ny    = (numy_ff > NUM_W'(lasty)) ? lasty : DIM_W'(numy_ff);
      mx    = orient_ff[2] ? lastx - nx : nx;
      case (orient_ff[1:0])
         2'd1: begin
            sx_w = ny;
            sy_w = lasth - mx;
         end
         2'd2: begin
            sx_w = lastw - mx;
            sy_w = lasth - ny;
         end
         2'd3: begin
            sx_w = lastw - ny;
            sy_w = mx;
         end
         default: begin
            sx_w = mx;
            sy_w = ny;
         end
      endcase
   end

   // Next values.
   always_comb begin
      w_in      = w_ff;
      h_in      = h_ff;
      nw_in     = nw_ff;
      nh_in     = nh_ff;
      ow_in     = ow_ff;
      oh_in     = oh_ff;
      orient_in = orient_ff;
      numx_in   = numx_ff;
      numy_in   = numy_ff;
      remx_in   = remx_ff;
      remy_in   = remy_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      sx_in     = sx_ff;
      sy_in     = sy_ff;
      if (creq.start) begin
         w_in      = w_c;
         h_in      = h_c;
         nw_in     = nw_c;
         nh_in     = nh_c;
         ow_in     = ow_c;
         oh_in     = oh_c;
         orient_in = cfg.orientation;
         numx_in   = NUM_W'(creq.out_x) * NUM_W'(nw_c);
         numy_in   = NUM_W'(creq.out_y) * NUM_W'(nh_c);
         remx_in   = '0;
         remy_in   = '0;
         cnt_in    = '0;
         busy_in   = 1'b1;
      end else if (iterate) begin
         numx_in = {numx_ff[NUM_W-2:0], gex};
         numy_in = {numy_ff[NUM_W-2:0], gey};
         remx_in = gex ? DIM_W'(shx - {1'b0, ow_ff}) : DIM_W'(shx);
         remy_in = gey ? DIM_W'(shy - {1'b0, oh_ff}) : DIM_W'(shy);
         cnt_in  = cnt_ff + DIV_CNT_W'(1);
      end else if (finish) begin
         sx_in   = COORD_W'(sx_w);
         sy_in   = COORD_W'(sy_w);
         busy_in = 1'b0;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff      <= w_in;
      h_ff      <= h_in;
      nw_ff     <= nw_in;
      nh_ff     <= nh_in;
      ow_ff     <= ow_in;
      oh_ff     <= oh_in;
      orient_ff <= orient_in;
      numx_ff   <= numx_in;
      numy_ff   <= numy_in;
      remx_ff   <= remx_in;
      remy_ff   <= remy_in;
      sx_ff     <= sx_in;
      sy_ff     <= sy_in;
   end

   assign crsp.done = done_ff;
   assign crsp.sx   = sx_ff;
   assign crsp.sy   = sy_ff;

endmodule
`default_nettype wire

@@ rtl/yrs_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yrs_back: store and conversion back end
// Executes queued words: store writes, or pixel reads through the coordinate
// unit, the frame stores and the BT.601 conversion into the response register.
// ----------------------------------------------------------------------------
module yrs_back import yrs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  queue_type     q,
   output logic          pop,
   output coord_req_type creq,
   input  coord_rsp_type crsp,
   yrs_rsp_if.source     rsp
);

   localparam int LA_W  = COORD_W + DIM_W + 1;
   localparam int CAF_W = COORD_W + DIM_W + 1;

   state_type state_ff, state_in;

   logic [LUMA_AW-1:0] la_ff, la_in;
   logic [CA_AW-1:0]   ca_ff, ca_in;
   logic [BYTE_W-1:0]  y_ff, y_in, u_ff, u_in, v_ff, v_in;
   logic signed [CONV_W-1:0] py_ff, py_in, pr_ff, pr_in, pb_ff, pb_in;
   logic signed [CONV_W-1:0] pgu_ff, pgu_in, pgv_ff, pgv_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]   red_ff, red_in, green_ff, green_in, blue_ff, blue_in;

   // Sequencer outputs.
   logic               is_write, is_read;
   logic               luma_we, luma_re, ca_we, ca_re, cb_we, cb_re;
   logic [LUMA_AW-1:0] luma_addr;
   logic [CA_AW-1:0]   ca_addr;
   logic [CB_AW-1:0]   cb_addr;
   logic               load_addr, cap_yuv, cap_v2, load_prod, out_load;
   logic               out_free;

   logic [BYTE_W-1:0]  luma_rdata, ca_rdata, cb_rdata;
   logic [LA_W-1:0]    la_full;
   logic [CAF_W-1:0]   ca_full;
   logic signed [PIX_W+1:0]  c_v, d_v, e_v;
   logic signed [CONV_W-1:0] sum_r, sum_g, sum_b;

   function automatic logic [PIX_W-1:0] clamp_ch(input logic signed [CONV_W-1:0] s);
      logic [PIX_W-1:0] r;
      r = s[FRAC_W+PIX_W-1:FRAC_W];
      if (s < 0) begin
         r = '0;
      end else if (s[CONV_W-1:FRAC_W+PIX_W] != '0) begin
         r = '1;
      end
      return r;
   endfunction

   assign is_write = q.valid && (q.item.op != OP_READ);
   assign is_read  = q.valid && (q.item.op == OP_READ);
   assign out_free = !rsp_valid_ff || rsp.ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (is_read) state_in = ST_MAP;
         ST_MAP:  if (crsp.done) state_in = ST_ADDR;
         ST_ADDR: state_in = ST_RD0;
         ST_RD0:  state_in = ST_RD1;
         ST_RD1:  state_in = ST_RD2;
         ST_RD2:  state_in = ST_MUL;
         ST_MUL:  state_in = ST_OUT;
         ST_OUT:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs: store ports, capture enables and queue pop.
   always_comb begin
      pop       = 1'b0;
      creq.start = 1'b0;
      luma_we   = 1'b0;
      luma_re   = 1'b0;
      ca_we     = 1'b0;
      ca_re     = 1'b0;
      cb_we     = 1'b0;
      cb_re     = 1'b0;
      luma_addr = la_ff;
      ca_addr   = ca_ff;
      cb_addr   = CB_AW'(ca_ff);
      load_addr = 1'b0;
      cap_yuv   = 1'b0;
      cap_v2    = 1'b0;
      load_prod = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            pop        = q.valid;
            creq.start = is_read;
            luma_addr  = LUMA_AW'(q.item.address);
            ca_addr    = CA_AW'(q.item.address);
            cb_addr    = CB_AW'(q.item.address);
            luma_we    = is_write && (q.item.op == OP_WR_LUMA);
            ca_we      = is_write && (q.item.op == OP_WR_CA);
            cb_we      = is_write && (q.item.op == OP_WR_CB);
         end
         ST_MAP:  load_addr = crsp.done;
         ST_ADDR: load_addr = 1'b1;
         ST_RD0: begin
            luma_re = 1'b1;
            ca_re   = 1'b1;
            cb_re   = 1'b1;
         end
         ST_RD1: begin
            cap_yuv = 1'b1;
            ca_re   = 1'b1;
            ca_addr = ca_ff + CA_AW'(1);
         end
         ST_RD2:  cap_v2 = cfg.chroma_format;
         ST_MUL:  load_prod = 1'b1;
         ST_OUT:  out_load = out_free;
         default: pop = 1'b0;
      endcase
   end

   assign creq.out_x = q.item.out_x;
   assign creq.out_y = q.item.out_y;

   // Frame stores.
   yrs_ram #(.WIDTH(BYTE_W), .DEPTH(LUMA_DEPTH)) u_luma (
      .clock (clock),
      .we    (luma_we),
      .re    (luma_re),
      .addr  (luma_addr),
      .wdata (q.item.value),
      .rdata (luma_rdata)
   );

   yrs_ram #(.WIDTH(BYTE_W), .DEPTH(CA_DEPTH)) u_chroma_a (
      .clock (clock),
      .we    (ca_we),
      .re    (ca_re),
      .addr  (ca_addr),
      .wdata (q.item.value),
      .rdata (ca_rdata)
   );

   yrs_ram #(.WIDTH(BYTE_W), .DEPTH(CB_DEPTH)) u_chroma_b (
      .clock (clock),
      .we    (cb_we),
      .re    (cb_re),
      .addr  (cb_addr),
      .wdata (q.item.value),
      .rdata (cb_rdata)
   );

   // Store addresses from the source pixel; chroma rows cover two luma rows.
   always_comb begin
      la_full = LA_W'(crsp.sy) * LA_W'(cfg.luma_stride) + LA_W'(crsp.sx);
      ca_full = CAF_W'(crsp.sy >> 1) * CAF_W'(cfg.chroma_stride);
      if (cfg.chroma_format) begin
         ca_full = ca_full + (CAF_W'(crsp.sx >> 1) << 1);
      end else begin
         ca_full = ca_full + CAF_W'(crsp.sx >> 1);
      end
   end

   // Offset samples and the conversion sums.
   always_comb begin
      c_v   = $signed({2'b00, y_ff}) - 10'sd16;
      d_v   = $signed({2'b00, u_ff}) - 10'sd128;
      e_v   = $signed({2'b00, v_ff}) - 10'sd128;
      sum_r = py_ff + pr_ff + C_ROUND;
      sum_g = py_ff - pgu_ff - pgv_ff + C_ROUND;
      sum_b = py_ff + pb_ff + C_ROUND;
   end

   // Datapath next values.
   always_comb begin
      la_in    = load_addr ? LUMA_AW'(la_full) : la_ff;
      ca_in    = load_addr ? CA_AW'(ca_full) : ca_ff;
      y_in     = cap_yuv ? luma_rdata : y_ff;
      u_in     = cap_yuv ? ca_rdata : u_ff;
      v_in     = v_ff;
      if (cap_yuv) begin
         v_in = cb_rdata;
      end else if (cap_v2) begin
         v_in = ca_rdata;
      end
      py_in    = load_prod ? CONV_W'(c_v) * C_Y : py_ff;
      pr_in    = load_prod ? CONV_W'(e_v) * C_RV : pr_ff;
      pgu_in   = load_prod ? CONV_W'(d_v) * C_GU : pgu_ff;
      pgv_in   = load_prod ? CONV_W'(e_v) * C_GV : pgv_ff;
      pb_in    = load_prod ? CONV_W'(d_v) * C_BU : pb_ff;
      red_in   = out_load ? clamp_ch(sum_r) : red_ff;
      green_in = out_load ? clamp_ch(sum_g) : green_ff;
      blue_in  = out_load ? clamp_ch(sum_b) : blue_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      la_ff    <= la_in;
      ca_ff    <= ca_in;
      y_ff     <= y_in;
      u_ff     <= u_in;
      v_ff     <= v_in;
      py_ff    <= py_in;
      pr_ff    <= pr_in;
      pgu_ff   <= pgu_in;
      pgv_ff   <= pgv_in;
      pb_ff    <= pb_in;
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
   end

   // Response register.
   assign rsp.valid = rsp_valid_ff;
   assign rsp.red   = red_ff;
   assign rsp.green = green_ff;
   assign rsp.blue  = blue_ff;

endmodule
`default_nettype wire

@@ rtl/yuv420_to_rgba_rotate_scale.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yuv420_to_rgba_rotate_scale: YUV 4:2:0 frame store with RGB readout
// Request words either write one byte into the luma store or a chroma store,
// or name an output pixel; a pixel request returns one RGB response word
// taken from the source pixel chosen by scaling, mirror and rotation.
// Channels: req_bus (op, address, value, out_x, out_y), rsp_bus (red, green,
// blue) and csr_bus (index, data), each with valid/ready; a word moves when
// valid and ready are both high at a rising clock edge. csr_ready is always
// high; registers are to be written only while no request is in flight, which
// the block does not enforce. A two-word queue sits behind req_bus. A write
// retires one per cycle at the queue head while the back end is idle. A pixel
// read runs from the queue head through the 17-step bit-serial divider of the
// coordinate unit and the stores to rsp_valid; reads are worked one at a time.
// Reset (synchronous, active high) empties the queue, drops any pending
// response and loads the register defaults; store contents are left as they
// are and are undefined until written. When the receiver holds rsp_ready low,
// the response register keeps its word, the back end stops at the next
// finished read and the queue fills, after which req_ready falls.
// ----------------------------------------------------------------------------
module yuv420_to_rgba_rotate_scale import yrs_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   yrs_req_if.sink   req_bus,
   yrs_rsp_if.source rsp_bus,
   yrs_csr_if.sink   csr_bus
);

   cfg_type       cfg_ff, cfg_in;
   queue_type     q;
   logic          pop;
   coord_req_type creq;
   coord_rsp_type crsp;

   // Register file.
   assign csr_bus.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_idx_type'(csr_bus.index))
            CSR_SRC_WIDTH:     cfg_in.src_width     = DIM_W'(csr_bus.data);
            CSR_SRC_HEIGHT:    cfg_in.src_height    = DIM_W'(csr_bus.data);
            CSR_OUT_WIDTH:     cfg_in.out_width     = DIM_W'(csr_bus.data);
            CSR_OUT_HEIGHT:    cfg_in.out_height    = DIM_W'(csr_bus.data);
            CSR_ORIENTATION:   cfg_in.orientation   = ORIENT_W'(csr_bus.data);
            CSR_CHROMA_FORMAT: cfg_in.chroma_format = csr_bus.data[0];
            CSR_LUMA_STRIDE:   cfg_in.luma_stride   = DIM_W'(csr_bus.data);
            CSR_CHROMA_STRIDE: cfg_in.chroma_stride = DIM_W'(csr_bus.data);
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.src_width     <= DIM_W'(256);
         cfg_ff.src_height    <= DIM_W'(256);
         cfg_ff.out_width     <= '0;
         cfg_ff.out_height    <= '0;
         cfg_ff.orientation   <= '0;
         cfg_ff.chroma_format <= 1'b0;
         cfg_ff.luma_stride   <= DIM_W'(256);
         cfg_ff.chroma_stride <= DIM_W'(128);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end queue.
   yrs_front u_front (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .q     (q),
      .pop   (pop)
   );

   // Coordinate mapper.
   yrs_coord u_coord (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .creq  (creq),
      .crsp  (crsp)
   );

   // Back end.
   yrs_back u_back (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .q     (q),
      .pop   (pop),
      .creq  (creq),
      .crsp  (crsp),
      .rsp   (rsp_bus)
   );

`ifndef ASSERT_OFF
   // The back end only takes words that the queue holds.
   a_pop_has_word: assert property (@(posedge clock) disable iff (reset)
      pop |-> q.valid)
      else $error("queue popped while empty");

   // The divider never finishes in the cycle after it starts.
   a_map_not_instant: assert property (@(posedge clock) disable iff (reset)
      creq.start |=> !crsp.done)
      else $error("coordinate unit finished too early");

   // A new mapping never starts while a finished one is being handed over.
   a_map_no_overlap: assert property (@(posedge clock) disable iff (reset)
      crsp.done |-> !creq.start)
      else $error("coordinate unit restarted during handover");
`endif

endmodule
`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench of the YUV 4:2:0 frame store with RGB readout
// Loads luma and chroma bytes and then requests output pixels. A directed
// table is walked first, then phases of random traffic run under several
// register settings. Before each random pixel read the bench writes any
// source byte the read will touch that was never stored. Each response word
// is checked against its table row or a BT.601 mapping of the shadowed stores.
// ----------------------------------------------------------------------------
module tb;
   import yrs_pkg::*;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_t;

   typedef struct {
      op_type     op;
      logic [15:0] address;
      logic [7:0] value;
      logic [7:0] ox;
      logic [7:0] oy;
      bit         typed;
      pixel_t     pix;
   } table_row_t;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 40;
   localparam int ITEM_TARGET  = 1850;
   localparam int PHASE_ITEMS  = 200;

   logic clock;
   logic reset;

   yrs_req_if req_bus ();
   yrs_rsp_if rsp_bus ();
   yrs_csr_if csr_bus ();

   yuv420_to_rgba_rotate_scale u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Shadow stores, their written flags and the shadow registers.
   logic [7:0] luma_mem [LUMA_DEPTH];
   logic [7:0] ca_mem [CA_DEPTH];
   logic [7:0] cb_mem [CB_DEPTH];
   bit         luma_set [LUMA_DEPTH];
   bit         ca_set [CA_DEPTH];
   bit         cb_set [CB_DEPTH];
   cfg_type    shadow_cfg;

   pixel_t     expected_pixels [$];
   int         mismatches  = 0;
   int         sent_words  = 0;
   int         cycles      = 0;
   int         send_pct    = 0;
   int         stall_pct   = 0;
   bit         hold_request = 0;
   bit         hold_done   = 0;
   int         hold_left   = 0;
   bit         pause_done  = 0;

   // Directed table, run under the register defaults.
   table_row_t directed [16] = '{
      '{OP_WR_LUMA, 16'd0,     8'd16,  8'd0,   8'd0,   1'b0, '{8'd0, 8'd0, 8'd0}},
      '{OP_WR_CA,   16'd0,     8'd128, 8'd0,   8'd0,   1'b0, '{8'd0, 8'd0, 8'd0}},
      '{OP_WR_CB,   16'd0,     8'd128, 8'd0,   8'd0,   1'b0, '{8'd0, 8'd0, 8'd0}},
      '{OP_READ,    16'd0,     8'd0,   8'd0,   8'd0,   1'b1, '{8'd0, 8'd0, 8'd0}},
      '{OP_WR_LUMA, 16'd1,     8'd255, 8'd0,   8'd0,   1'b0, '{8'd0, 8'd0, 8'd0}},
      '{OP_READ,    16'd0,     8'd0,   8'd1,   8'd0,   1'b1, '{8'd255, 8'd255, 8'd255}},
      '{OP_WR_LUMA, 16'd2,     8'd0,   8'd0,   8'd0,   1'b0, '{8'd0, 8'd0, 8'd0}},
      '{OP_WR_CA,   16'd1,     8'd255, 8'd0,   8'd0,   1'b0, '{8'd0, 8'd0, 8'd0}},
      '{OP_WR_CB,   16'd1,     8'd0,   8'd0,   8'd0,   1'b0, '{8'd0, 8'd0, 8'd0}},
      '{OP_READ,    16'd0,     8'd0,   8'd2,   8'd0,   1'b1, '{8'd0, 8'd36, 8'd237}},
      '{OP_WR_LUMA, 16'd65535, 8'd255, 8'd0,   8'd0,   1'b0, '{8'd0, 8'd0, 8'd0}},
      '{OP_WR_CA,   16'd16383, 8'd0,   8'd0,   8'd0,   1'b0, '{8'd0, 8'd0, 8'd0}},
      '{OP_WR_CB,   16'd16383, 8'd255, 8'd0,   8'd0,   1'b0, '{8'd0, 8'd0, 8'd0}},
      '{OP_READ,    16'd0,     8'd0,   8'd255, 8'd255, 1'b1, '{8'd255, 8'd225, 8'd20}},
      // The second chroma address wraps onto the last entry of its store.
      '{OP_WR_CB,   16'd65535, 8'd128, 8'd0,   8'd0,   1'b0, '{8'd0, 8'd0, 8'd0}},
      '{OP_READ,    16'd65535, 8'd255, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd255, 8'd20}}
   };

   // Clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic int clip(input int v, input int lo, input int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // Natural and output frame sizes under the current registers.
   function automatic void frame_dims(output int w, output int h, output int nw,
                                      output int nh, output int ow, output int oh);
      w  = clip(int'(shadow_cfg.src_width), 1, MAX_WIDTH);
      h  = clip(int'(shadow_cfg.src_height), 1, MAX_HEIGHT);
      nw = shadow_cfg.orientation[0] ? h : w;
      nh = shadow_cfg.orientation[0] ? w : h;
      ow = nw;
      oh = nh;
      if (!shadow_cfg.chroma_format) begin
         if (shadow_cfg.out_width != 0) ow = clip(int'(shadow_cfg.out_width), 1, MAX_WIDTH);
         if (shadow_cfg.out_height != 0)
            oh = clip(int'(shadow_cfg.out_height), 1, MAX_HEIGHT);
      end
   endfunction

   // Store addresses of the source pixel behind one output pixel. The V byte
   // lives in the second chroma store only in planar mode.
   function automatic void locate_source(input logic [7:0] ox, input logic [7:0] oy,
                                         output int la, output int ua, output int va);
      int w, h, nw, nh, ow, oh, nx, ny, mx, sx, sy, ca;
      frame_dims(w, h, nw, nh, ow, oh);
      nx = int'(ox) * nw / ow;
      if (nx > nw - 1) nx = nw - 1;
      ny = int'(oy) * nh / oh;
      if (ny > nh - 1) ny = nh - 1;
      mx = shadow_cfg.orientation[2] ? nw - 1 - nx : nx;
      case (shadow_cfg.orientation[1:0])
         2'd1: begin sx = ny;         sy = h - 1 - mx; end
         2'd2: begin sx = w - 1 - mx; sy = h - 1 - ny; end
         2'd3: begin sx = w - 1 - ny; sy = mx;         end
         default: begin sx = mx;      sy = ny;         end
      endcase
      la = (sy * int'(shadow_cfg.luma_stride) + sx) % LUMA_DEPTH;
      if (!shadow_cfg.chroma_format) begin
         ca = (sy / 2) * int'(shadow_cfg.chroma_stride) + sx / 2;
         ua = ca % CA_DEPTH;
         va = ca % CB_DEPTH;
      end else begin
         ca = (sy / 2) * int'(shadow_cfg.chroma_stride) + (sx / 2) * 2;
         ua = ca % CA_DEPTH;
         va = (ca + 1) % CA_DEPTH;
      end
   endfunction

   function automatic logic [7:0] saturate_byte(input int sum);
      if (sum < 0) return 8'd0;
      if ((sum >>> 8) > 255) return 8'd255;
      return 8'(sum >>> 8);
   endfunction

   // BT.601 integer conversion of the source pixel behind an output pixel.
   function automatic pixel_t predict_pixel(input logic [7:0] ox, input logic [7:0] oy);
      int la, ua, va, c, d, e;
      pixel_t p;
      locate_source(ox, oy, la, ua, va);
      c = int'(luma_mem[la]) - 16;
      d = int'(ca_mem[ua]) - 128;
      e = shadow_cfg.chroma_format ? int'(ca_mem[va]) - 128 : int'(cb_mem[va]) - 128;
      p.red   = saturate_byte(298 * c + 409 * e + 128);
      p.green = saturate_byte(298 * c - 100 * d - 208 * e + 128);
      p.blue  = saturate_byte(298 * c + 516 * d + 128);
      return p;
   endfunction

   // Shadow update for one accepted request word.
   function automatic void absorb_word(input item_type it, input bit typed,
                                       input pixel_t typed_pix);
      int a;
      a = int'(it.address);
      case (it.op)
         OP_WR_LUMA: begin luma_mem[a % LUMA_DEPTH] = it.value; luma_set[a % LUMA_DEPTH] = 1; end
         OP_WR_CA:   begin ca_mem[a % CA_DEPTH] = it.value; ca_set[a % CA_DEPTH] = 1; end
         OP_WR_CB:   begin cb_mem[a % CB_DEPTH] = it.value; cb_set[a % CB_DEPTH] = 1; end
         default: expected_pixels.insert(expected_pixels.size(),
                     typed ? typed_pix : predict_pixel(it.out_x, it.out_y));
      endcase
   endfunction

   // Offer one request word, with random idle gaps, until it is taken.
   task automatic send_word(input item_type it, input bit typed, input pixel_t typed_pix);
      bit taken;
      taken = 0;
      @(negedge clock);
      while ($urandom_range(99) < send_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.op      <= it.op;
      req_bus.address <= it.address;
      req_bus.value   <= it.value;
      req_bus.out_x   <= it.out_x;
      req_bus.out_y   <= it.out_y;
      while (!taken) begin
         @(posedge clock);
         taken = req_bus.ready;
      end
      absorb_word(it, typed, typed_pix);
      sent_words++;
   endtask

   task automatic send_write(input op_type op, input int address, input logic [7:0] value);
      item_type it;
      it = '{op: op, address: 16'(address), value: value,
             out_x: 8'($urandom), out_y: 8'($urandom)};
      send_word(it, 1'b0, '0);
   endtask

   // A pixel read, preceded by writes of any source byte not yet stored.
   // Chroma write addresses carry random upper bits so they wrap onto the entry.
   task automatic send_read(input logic [7:0] ox, input logic [7:0] oy);
      int la, ua, va;
      item_type it;
      locate_source(ox, oy, la, ua, va);
      if (!luma_set[la]) send_write(OP_WR_LUMA, la, 8'($urandom));
      if (!ca_set[ua]) send_write(OP_WR_CA, ua + CA_DEPTH * $urandom_range(1), 8'($urandom));
      if (shadow_cfg.chroma_format) begin
         if (!ca_set[va]) send_write(OP_WR_CA, va + CA_DEPTH * $urandom_range(1), 8'($urandom));
      end else if (!cb_set[va]) begin
         send_write(OP_WR_CB, va + CB_DEPTH * $urandom_range(3), 8'($urandom));
      end
      it = '{op: OP_READ, address: 16'($urandom), value: 8'($urandom), out_x: ox, out_y: oy};
      send_word(it, 1'b0, '0);
   endtask

   task automatic release_req();
      @(negedge clock);
      req_bus.valid <= 1'b0;
   endtask

   // Wait for every response, then for the tail of any write in flight.
   task automatic wait_idle();
      wait (expected_pixels.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input csr_idx_type idx, input logic [8:0] data);
      bit taken;
      taken = 0;
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      while (!taken) begin
         @(posedge clock);
         taken = csr_bus.ready;
      end
      case (idx)
         CSR_SRC_WIDTH:     shadow_cfg.src_width     = data;
         CSR_SRC_HEIGHT:    shadow_cfg.src_height    = data;
         CSR_OUT_WIDTH:     shadow_cfg.out_width     = data;
         CSR_OUT_HEIGHT:    shadow_cfg.out_height    = data;
         CSR_ORIENTATION:   shadow_cfg.orientation   = data[2:0];
         CSR_CHROMA_FORMAT: shadow_cfg.chroma_format = data[0];
         CSR_LUMA_STRIDE:   shadow_cfg.luma_stride   = data;
         default:           shadow_cfg.chroma_stride = data;
      endcase
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic load_setting(input cfg_type c);
      write_register(CSR_SRC_WIDTH, c.src_width);
      write_register(CSR_SRC_HEIGHT, c.src_height);
      write_register(CSR_OUT_WIDTH, c.out_width);
      write_register(CSR_OUT_HEIGHT, c.out_height);
      write_register(CSR_ORIENTATION, 9'(c.orientation));
      write_register(CSR_CHROMA_FORMAT, 9'(c.chroma_format));
      write_register(CSR_LUMA_STRIDE, c.luma_stride);
      write_register(CSR_CHROMA_STRIDE, c.chroma_stride);
   endtask

   // Mostly small frames; now and then a size out of the legal range.
   function automatic logic [8:0] random_size();
      if ($urandom_range(9) == 0) return 9'($urandom_range(0, 511));
      return 9'($urandom_range(1, 20));
   endfunction

   function automatic logic [8:0] random_target();
      case ($urandom_range(5))
         0, 1:    return 9'd0;
         2:       return 9'($urandom_range(0, 511));
         default: return 9'($urandom_range(1, 40));
      endcase
   endfunction

   // Response ready: one long hold-off on request, otherwise random stalls.
   always @(negedge clock) begin
      if (hold_request && !hold_done) begin
         hold_left = 400;
         hold_done = 1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Response checker.
   always @(posedge clock) begin
      pixel_t want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response word r=%0d g=%0d b=%0d",
                        rsp_bus.red, rsp_bus.green, rsp_bus.blue);
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_bus.red !== want.red || rsp_bus.green !== want.green ||
                rsp_bus.blue !== want.blue) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("pixel mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                           want.red, want.green, want.blue,
                           rsp_bus.red, rsp_bus.green, rsp_bus.blue);
            end
         end
      end
   end

   // Stimulus.
   initial begin
      cfg_type c;
      item_type it;
      int phase, phase_end, w, h, nw, nh, ow, oh;
      logic [7:0] ox, oy;

      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.op      = OP_WR_LUMA;
      req_bus.address = '0;
      req_bus.value   = '0;
      req_bus.out_x   = '0;
      req_bus.out_y   = '0;
      csr_bus.valid   = 1'b0;
      csr_bus.index   = CSR_SRC_WIDTH;
      csr_bus.data    = '0;
      rsp_bus.ready   = 1'b0;
      shadow_cfg = '{src_width: 9'd256, src_height: 9'd256, out_width: 9'd0,
                     out_height: 9'd0, orientation: 3'd0, chroma_format: 1'b0,
                     luma_stride: 9'd256, chroma_stride: 9'd128};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table under the reset defaults.
      foreach (directed[i]) begin
         it = '{op: directed[i].op, address: directed[i].address, value: directed[i].value,
                out_x: directed[i].ox, out_y: directed[i].oy};
         send_word(it, directed[i].typed, directed[i].pix);
      end

      // Random phases, each under its own register setting and idle pattern.
      phase = 0;
      while (sent_words < ITEM_TARGET) begin
         release_req();
         wait_idle();
         case (phase)
            0: c = '{9'd256, 9'd256, 9'd256, 9'd256, 3'd7, 1'b0, 9'd256, 9'd256};
            1: c = '{9'd1, 9'd1, 9'd0, 9'd0, 3'd0, 1'b1, 9'd0, 9'd0};
            2: c = '{9'd0, 9'd511, 9'd511, 9'd1, 3'd5, 1'b0, 9'd511, 9'd0};
            3: c = '{9'd2, 9'd3, 9'd1, 9'd256, 3'd3, 1'b1, 9'd1, 9'd511};
            default: c = '{random_size(), random_size(), random_target(), random_target(),
                           3'($urandom_range(7)), 1'($urandom_range(1)),
                           9'($urandom_range(0, 511)), 9'($urandom_range(0, 511))};
         endcase
         load_setting(c);
         case (phase % 4)
            0: begin send_pct = 0;  stall_pct = 0;  end
            1: begin send_pct = 46; stall_pct = 0;  end
            2: begin send_pct = 0;  stall_pct = 46; end
            default: begin send_pct = 17; stall_pct = 17; end
         endcase
         frame_dims(w, h, nw, nh, ow, oh);
         phase_end = sent_words + PHASE_ITEMS;
         while (sent_words < phase_end) begin
            // Long receiver hold-off while requests keep coming.
            if (phase == 4 && !hold_request &&
                sent_words >= phase_end - PHASE_ITEMS + 20) begin
               send_pct = 0;
               hold_request = 1;
            end
            // Sender pause until the pipe has drained.
            if (phase == 5 && !pause_done && sent_words >= phase_end - PHASE_ITEMS / 2) begin
               pause_done = 1;
               release_req();
               wait (expected_pixels.size() == 0);
            end
            if ($urandom_range(99) < 70) begin
               if ($urandom_range(4) == 0) begin
                  ox = 8'($urandom);
                  oy = 8'($urandom);
               end else begin
                  ox = 8'($urandom_range(0, clip(ow, 1, 256) - 1));
                  oy = 8'($urandom_range(0, clip(oh, 1, 256) - 1));
               end
               send_read(ox, oy);
            end else begin
               send_write(op_type'($urandom_range(0, 2)),
                          ($urandom_range(1) != 0) ? $urandom_range(0, 65535)
                                                   : $urandom_range(0, 2047),
                          8'($urandom));
            end
         end
         phase++;
      end

      release_req();
      wait (expected_pixels.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
